/* src/hpp_pkg.sv */
// ----------------------------------------------------------------------------
// hpp_pkg
// shared types, widths and constants of the homogeneous point projection
// ----------------------------------------------------------------------------
package hpp_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int PT_W      = 32;
   localparam int OUT_W     = 48;

   // configuration port
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_LO = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_HI = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_HI = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_LO = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_HI = CSR_IDX_W'(5);

   // identity camera after reset: 1.0 on the diagonal of the left 3x3
   localparam logic [CSR_W-1:0] FIX_ONE      = CSR_W'(64'd1 << FRAC_BITS);
   localparam logic [CSR_W-1:0] RST_ROW0_LO  = FIX_ONE;
   localparam logic [CSR_W-1:0] RST_ROW0_HI  = '0;
   localparam logic [CSR_W-1:0] RST_ROW1_LO  = FIX_ONE << PT_W;
   localparam logic [CSR_W-1:0] RST_ROW1_HI  = '0;
   localparam logic [CSR_W-1:0] RST_ROW2_LO  = '0;
   localparam logic [CSR_W-1:0] RST_ROW2_HI  = FIX_ONE;

   // datapath widths
   localparam int PROD_W   = 2 * PT_W;
   localparam int TERM_W   = PROD_W - FRAC_BITS;
   localparam int SUM_W    = TERM_W + 2;
   localparam int MAG_W    = SUM_W - 1;
   localparam int INT_BITS = 31;
   localparam int Q_W      = INT_BITS + FRAC_BITS;
   localparam int FIN_W    = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W;

   // saturation limits as quotient magnitudes
   localparam logic [Q_W-1:0] POS_SAT = Q_W'(64'd2147483644 << FRAC_BITS);
   localparam logic [Q_W-1:0] NEG_SAT = Q_W'(64'd2147483645 << FRAC_BITS);

   // both coordinates of a point behind the camera
   localparam logic [FIN_W-1:0] BEHIND_WIDE = FIN_W'(0) - FIN_W'(64'd65535 << FRAC_BITS);
   localparam logic [OUT_W-1:0] BEHIND_UV   = BEHIND_WIDE[OUT_W-1:0];

   typedef logic [2:0][3:0][PT_W-1:0] matrix_type;

   typedef struct packed {
      logic signed [PT_W-1:0] point_x;
      logic signed [PT_W-1:0] point_y;
      logic signed [PT_W-1:0] point_z;
      logic signed [PT_W-1:0] point_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] image_u;
      logic signed [OUT_W-1:0] image_v;
      logic                    behind_camera;
   } rsp_payload_type;

   // one division job handed from the matrix stages to the divider
   typedef struct packed {
      logic             behind;
      logic             neg_u;
      logic             neg_v;
      logic             sat_u;
      logic             sat_v;
      logic [MAG_W-1:0] num_u;
      logic [MAG_W-1:0] num_v;
      logic [MAG_W-1:0] den;
   } quot_job_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [Q_W-1:0]   acc;
   } div_lane_type;

   typedef struct packed {
      logic             behind;
      logic             neg_u;
      logic             neg_v;
      logic             sat_u;
      logic             sat_v;
      logic [MAG_W-1:0] den;
      div_lane_type     lane_u;
      div_lane_type     lane_v;
   } div_stage_type;

endpackage

/* src/hpp_matrix_mac.sv */
// ----------------------------------------------------------------------------
// hpp_matrix_mac
// 3x4 matrix times point: multiply, two adder levels, sign split, overflow test
// ----------------------------------------------------------------------------
module hpp_matrix_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_vld,
   input  hpp_pkg::req_payload_type in_pt,
   input  hpp_pkg::matrix_type     matrix,
   output logic                    job_vld,
   output hpp_pkg::quot_job_type   job
);
   import hpp_pkg::*;

   logic signed [PT_W-1:0]   pt [4];
   logic signed [PROD_W-1:0] prod_ff [3][4];
   logic signed [TERM_W:0]   pair_ff [3][2];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic [MAG_W-1:0]         mag_ff [2];
   logic                     neg_ff [2];
   logic [MAG_W-1:0]         den_ff;
   logic                     behind_ff;
   quot_job_type             job_ff;
   quot_job_type             job_in;
   logic [4:0]               vld_ff;

   assign pt[0] = in_pt.point_x;
   assign pt[1] = in_pt.point_y;
   assign pt[2] = in_pt.point_z;
   assign pt[3] = in_pt.point_w;

   // overflow when the integer quotient cannot fit below 2^31
   always_comb begin
      job_in.behind = behind_ff;
      job_in.neg_u  = neg_ff[0];
      job_in.neg_v  = neg_ff[1];
      job_in.sat_u  = (mag_ff[0] >> INT_BITS) >= den_ff;
      job_in.sat_v  = (mag_ff[1] >> INT_BITS) >= den_ff;
      job_in.num_u  = mag_ff[0];
      job_in.num_v  = mag_ff[1];
      job_in.den    = den_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[r][c] <= $signed(matrix[r][c]) * pt[c];
            end
            // floor shift is the upper part of each product
            pair_ff[r][0] <= (TERM_W+1)'($signed(prod_ff[r][0][PROD_W-1:FRAC_BITS]))
                           + (TERM_W+1)'($signed(prod_ff[r][1][PROD_W-1:FRAC_BITS]));
            pair_ff[r][1] <= (TERM_W+1)'($signed(prod_ff[r][2][PROD_W-1:FRAC_BITS]))
                           + (TERM_W+1)'($signed(prod_ff[r][3][PROD_W-1:FRAC_BITS]));
            sum_ff[r] <= SUM_W'(pair_ff[r][0]) + SUM_W'(pair_ff[r][1]);
         end
         for (int k = 0; k < 2; k++) begin
            neg_ff[k] <= sum_ff[k][SUM_W-1];
            mag_ff[k] <= sum_ff[k][SUM_W-1] ? MAG_W'(-sum_ff[k]) : MAG_W'(sum_ff[k]);
         end
         den_ff    <= MAG_W'(sum_ff[2]);
         behind_ff <= sum_ff[2][SUM_W-1] || (sum_ff[2] == '0);
         job_ff    <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_vld};
      end
   end

   assign job_vld = vld_ff[4];
   assign job     = job_ff;

endmodule

/* src/hpp_div_pipe.sv */
// ----------------------------------------------------------------------------
// hpp_div_pipe
// restoring divider, one quotient bit per stage for u and v, then saturation
// ----------------------------------------------------------------------------
module hpp_div_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     job_vld,
   input  hpp_pkg::quot_job_type    job,
   output logic                     res_vld,
   output hpp_pkg::rsp_payload_type res
);
   import hpp_pkg::*;

   div_stage_type   stg_ff [Q_W+1];
   div_stage_type   stg_in [Q_W+1];
   logic [Q_W:0]    vld_ff;
   rsp_payload_type res_ff;
   rsp_payload_type res_in;
   logic            res_vld_ff;

   function automatic div_lane_type lane_step(div_lane_type l, logic [MAG_W-1:0] d);
      logic [MAG_W:0] trial;
      logic           ge;
      div_lane_type   r;
      trial = {l.rem, l.acc[Q_W-1]};
      ge    = trial >= {1'b0, d};
      r.rem = ge ? MAG_W'(trial - {1'b0, d}) : trial[MAG_W-1:0];
      r.acc = {l.acc[Q_W-2:0], ge};
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] finish(logic [Q_W-1:0] q, logic sat, logic neg);
      logic [Q_W-1:0]   lim;
      logic [Q_W-1:0]   mag;
      logic [FIN_W-1:0] wide;
      lim  = neg ? NEG_SAT : POS_SAT;
      mag  = (sat || (q > lim)) ? lim : q;
      wide = FIN_W'(mag);
      if (neg) begin
         wide = FIN_W'(0) - wide;
      end
      return wide[OUT_W-1:0];
   endfunction

   // stage 0 loads the bits above the quotient window as first remainder
   always_comb begin
      stg_in[0].behind     = job.behind;
      stg_in[0].neg_u      = job.neg_u;
      stg_in[0].neg_v      = job.neg_v;
      stg_in[0].sat_u      = job.sat_u;
      stg_in[0].sat_v      = job.sat_v;
      stg_in[0].den        = job.den;
      stg_in[0].lane_u.rem = MAG_W'(job.num_u >> INT_BITS);
      stg_in[0].lane_u.acc = {job.num_u[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      stg_in[0].lane_v.rem = MAG_W'(job.num_v >> INT_BITS);
      stg_in[0].lane_v.acc = {job.num_v[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      for (int k = 1; k <= Q_W; k++) begin
         stg_in[k]        = stg_ff[k-1];
         stg_in[k].lane_u = lane_step(stg_ff[k-1].lane_u, stg_ff[k-1].den);
         stg_in[k].lane_v = lane_step(stg_ff[k-1].lane_v, stg_ff[k-1].den);
      end
   end

   always_comb begin
      res_in.behind_camera = stg_ff[Q_W].behind;
      if (stg_ff[Q_W].behind) begin
         res_in.image_u = BEHIND_UV;
         res_in.image_v = BEHIND_UV;
      end else begin
         res_in.image_u = finish(stg_ff[Q_W].lane_u.acc, stg_ff[Q_W].sat_u, stg_ff[Q_W].neg_u);
         res_in.image_v = finish(stg_ff[Q_W].lane_v.acc, stg_ff[Q_W].sat_v, stg_ff[Q_W].neg_v);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= Q_W; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         res_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[Q_W-1:0], job_vld};
         res_vld_ff <= vld_ff[Q_W];
      end
   end

   assign res_vld = res_vld_ff;
   assign res     = res_ff;

endmodule

/* src/hpp_out_skid.sv */
// ----------------------------------------------------------------------------
// hpp_out_skid
// two-entry output buffer, full flag comes straight from a register
// ----------------------------------------------------------------------------
module hpp_out_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  hpp_pkg::rsp_payload_type push_data,
   output logic                     full,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hpp_pkg::rsp_payload_type rsp_payload
);
   import hpp_pkg::*;

   logic [1:0]      count_ff;
   logic [1:0]      count_in;
   rsp_payload_type slot0_ff;
   rsp_payload_type slot0_in;
   rsp_payload_type slot1_ff;
   rsp_payload_type slot1_in;
   logic            pop;

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      count_in = 2'(count_ff + {1'b0, push} - {1'b0, pop});
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if ((count_ff == 2'd0) || pop) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full        = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot0_ff;

endmodule

/* src/homogeneous_point_projection.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_projection
// pinhole projection of a homogeneous point through a 3x4 camera matrix
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_ready  | point x, y, z, w (Q16.16)
//  rsp_     | out       | rsp_valid/rsp_ready  | image u, v (Q32.16), behind flag
//  csr_     | in        | csr_wr_en            | csr_index, csr_wdata (64 bits)
//
//  one point per cycle while the output buffer is not full; the divider retires
//  one quotient bit per stage
//  synchronous reset clears valid bits and buffer count, reloads identity camera
//  the whole pipeline moves together; it halts only when both output buffer
//  entries hold results, so one waiting result does not stop new points
// ----------------------------------------------------------------------------
module homogeneous_point_projection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  hpp_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hpp_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [hpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hpp_pkg::CSR_W-1:0]        csr_wdata
);
   import hpp_pkg::*;

   // camera matrix registers, two Q16.16 entries per register
   logic [CSR_W-1:0] row0_lo_ff;
   logic [CSR_W-1:0] row0_hi_ff;
   logic [CSR_W-1:0] row1_lo_ff;
   logic [CSR_W-1:0] row1_hi_ff;
   logic [CSR_W-1:0] row2_lo_ff;
   logic [CSR_W-1:0] row2_hi_ff;
   matrix_type       matrix;

   logic             adv;
   logic             skid_full;
   logic             in_vld;
   logic             job_vld;
   quot_job_type     job;
   logic             res_vld;
   rsp_payload_type  res;

   // register writes; indexes past the last register fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         row0_lo_ff <= RST_ROW0_LO;
         row0_hi_ff <= RST_ROW0_HI;
         row1_lo_ff <= RST_ROW1_LO;
         row1_hi_ff <= RST_ROW1_HI;
         row2_lo_ff <= RST_ROW2_LO;
         row2_hi_ff <= RST_ROW2_HI;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW0_LO: row0_lo_ff <= csr_wdata;
            CSR_ROW0_HI: row0_hi_ff <= csr_wdata;
            CSR_ROW1_LO: row1_lo_ff <= csr_wdata;
            CSR_ROW1_HI: row1_hi_ff <= csr_wdata;
            CSR_ROW2_LO: row2_lo_ff <= csr_wdata;
            CSR_ROW2_HI: row2_hi_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // low word of each register is the first entry of the pair
   assign matrix[0][0] = row0_lo_ff[PT_W-1:0];
   assign matrix[0][1] = row0_lo_ff[CSR_W-1:PT_W];
   assign matrix[0][2] = row0_hi_ff[PT_W-1:0];
   assign matrix[0][3] = row0_hi_ff[CSR_W-1:PT_W];
   assign matrix[1][0] = row1_lo_ff[PT_W-1:0];
   assign matrix[1][1] = row1_lo_ff[CSR_W-1:PT_W];
   assign matrix[1][2] = row1_hi_ff[PT_W-1:0];
   assign matrix[1][3] = row1_hi_ff[CSR_W-1:PT_W];
   assign matrix[2][0] = row2_lo_ff[PT_W-1:0];
   assign matrix[2][1] = row2_lo_ff[CSR_W-1:PT_W];
   assign matrix[2][2] = row2_hi_ff[PT_W-1:0];
   assign matrix[2][3] = row2_hi_ff[CSR_W-1:PT_W];

   // global advance, taken from a registered full flag only
   assign adv       = !skid_full;
   assign req_ready = adv;
   assign in_vld    = req_valid && req_ready;

   // products, row sums, sign split and overflow test
   hpp_matrix_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (in_vld),
      .in_pt   (req_payload),
      .matrix  (matrix),
      .job_vld (job_vld),
      .job     (job)
   );

   // u and v quotients against the shared depth, then clamping
   hpp_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .job_vld (job_vld),
      .job     (job),
      .res_vld (res_vld),
      .res     (res)
   );

   // output buffer decouples rsp_ready from the pipeline
   hpp_out_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .push        (res_vld && adv),
      .push_data   (res),
      .full        (skid_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/hpp_checker.sv */
// ----------------------------------------------------------------------------
// hpp_checker
// port level checks of the projection block, bound to the top level
// ----------------------------------------------------------------------------
module hpp_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_ready,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  hpp_pkg::rsp_payload_type rsp_payload
);
   import hpp_pkg::*;

   localparam logic [FIN_W-1:0]  POS_WIDE = FIN_W'(POS_SAT);
   localparam logic [FIN_W-1:0]  NEG_WIDE = FIN_W'(0) - FIN_W'(NEG_SAT);
   localparam logic signed [OUT_W-1:0] U_MAX = POS_WIDE[OUT_W-1:0];
   localparam logic signed [OUT_W-1:0] U_MIN = NEG_WIDE[OUT_W-1:0];

   // a held transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transaction changed before it was taken");

   // behind points carry the fixed marker coordinates
   a_behind_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.behind_camera |->
         (rsp_payload.image_u == BEHIND_UV) && (rsp_payload.image_v == BEHIND_UV))
      else $error("behind camera result without marker coordinates");

   // visible points stay inside the saturation window
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.behind_camera |->
         ($signed(rsp_payload.image_u) <= U_MAX) && ($signed(rsp_payload.image_u) >= U_MIN) &&
         ($signed(rsp_payload.image_v) <= U_MAX) && ($signed(rsp_payload.image_v) >= U_MIN))
      else $error("projected coordinate outside saturation range");

   // input stalls only while the output buffer holds results
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no result waiting");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result visible right after reset");

endmodule

bind homogeneous_point_projection hpp_checker u_hpp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
